[rtl/core/bfa_pkg.sv]
// Shared types, codes and constants for the best-fit block allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bfa_pkg;

  localparam int ADDR_W     = 13;
  localparam int LEN_W      = 14;
  localparam int OWN_W      = 16;
  localparam int MODE_W     = 2;
  localparam int STAT_W     = 3;
  localparam int GRAN_W     = 12;  // effective granule reaches 2048
  localparam int CFG_W      = 11;
  localparam int RND_W      = 15;  // rounded request can pass the pool size
  localparam int POOL_BYTES = 8192;
  localparam int MIN_GRAN   = 8;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_BADSIZE = 3'd1,
    ST_NOMEM   = 3'd2,
    ST_FULL    = 3'd3,
    ST_UNKNOWN = 3'd4,
    ST_SHORT   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    UPD_NONE  = 2'd0,
    UPD_WRITE = 2'd1,
    UPD_SHIFT = 2'd2
  } upd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DIV,
    S_HGO,
    S_HSCAN,
    S_HUPD,
    S_HUPD2,
    S_BGO,
    S_BSCAN,
    S_OUT
  } fsm_e;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  size;
  } hole_t;

  typedef struct packed {
    logic [OWN_W-1:0]  owner;
    logic [LEN_W-1:0]  req;
    logic [LEN_W-1:0]  act;
    logic [ADDR_W-1:0] addr;
  } blk_t;

  // Query travelling down the hole chain: best fit and neighbour search at once
  typedef struct packed {
    logic              vld;
    logic [RND_W-1:0]  rnd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              found;
    logic              exact;
    logic [ADDR_W-1:0] paddr;
    logic [LEN_W-1:0]  psize;
    logic              lfound;
    logic [ADDR_W-1:0] laddr;
    logic [LEN_W-1:0]  lsize;
    logic              rfound;
    logic [LEN_W-1:0]  rsize;
  } hole_qry_t;

  // Query travelling down the block chain: address lookup or range check
  typedef struct packed {
    logic              vld;
    logic              chk;
    logic [OWN_W-1:0]  owner;
    logic [ADDR_W-1:0] addr;
    logic              found;
    logic [ADDR_W-1:0] faddr;
    logic [LEN_W-1:0]  freq;
    logic [LEN_W-1:0]  fact;
  } blk_qry_t;

  typedef struct packed {
    upd_e  cmd;
    hole_t ent;
  } hole_upd_t;

  typedef struct packed {
    upd_e cmd;
    blk_t ent;
  } blk_upd_t;

endpackage

[rtl/core/bfa_gran_div.sv]
// Rounds a request up to the granule: restoring remainder, one bit a cycle.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_gran_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [bfa_pkg::LEN_W-1:0]  size_i,
  input  logic [bfa_pkg::GRAN_W-1:0] gran_i,
  output logic                       done_o,
  output logic [bfa_pkg::RND_W-1:0]  rnd_o
);
  import bfa_pkg::*;

  localparam int CNT_W = $clog2(LEN_W);

  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [LEN_W-1:0]   sh_q, sh_d;
  logic [LEN_W-1:0]   size_q, size_d;
  logic [GRAN_W-1:0]  rem_q, rem_d;
  logic [RND_W-1:0]   rnd_q, rnd_d;
  logic [GRAN_W:0]    trial;
  logic [GRAN_W:0]    diff;
  logic [GRAN_W-1:0]  pad;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    sh_d   = sh_q;
    size_d = size_q;
    rem_d  = rem_q;
    rnd_d  = rnd_q;
    trial  = {rem_q, sh_q[LEN_W-1]};
    diff   = trial - {1'b0, gran_i};
    pad    = '0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      sh_d   = size_i;
      size_d = size_i;
      rem_d  = '0;
    end else if (busy_q) begin
      rem_d = (trial >= {1'b0, gran_i}) ? diff[GRAN_W-1:0] : trial[GRAN_W-1:0];
      sh_d  = {sh_q[LEN_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CNT_W'(LEN_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
        pad    = (rem_d != '0) ? (gran_i - rem_d) : '0;
        rnd_d  = {1'b0, size_q} + RND_W'(pad);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sh_q   <= sh_d;
    size_q <= size_d;
    rem_q  <= rem_d;
    rnd_q  <= rnd_d;
  end

  assign done_o = done_q;
  assign rnd_o  = rnd_q;

endmodule

[rtl/core/bfa_hole_cell.sv]
// One cell of the free-hole chain: holds a hole, refines the passing query.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_hole_cell #(
  parameter int IDX      = 0,
  parameter int IW       = 7,
  parameter int CW       = 7,
  parameter bit IS_FIRST = 1'b0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [CW-1:0]         cnt_i,
  input  bfa_pkg::hole_qry_t    q_i,
  input  logic [IW-1:0]         pidx_i,
  input  logic [IW-1:0]         lidx_i,
  input  logic [IW-1:0]         ridx_i,
  output bfa_pkg::hole_qry_t    q_o,
  output logic [IW-1:0]         pidx_o,
  output logic [IW-1:0]         lidx_o,
  output logic [IW-1:0]         ridx_o,
  input  bfa_pkg::hole_upd_t    upd_i,
  input  logic [IW-1:0]         uidx_i,
  input  bfa_pkg::hole_t        nxt_i,
  output bfa_pkg::hole_t        ent_o
);
  import bfa_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);
  localparam hole_t         INIT   = IS_FIRST ? '{addr: '0, size: LEN_W'(POOL_BYTES)} : '0;

  hole_t            ent_q, ent_d;
  hole_qry_t        q_q, q_d;
  logic [IW-1:0]    p_q, p_d, l_q, l_d, r_q, r_d;
  logic             live;
  logic             ex, gt, take;
  logic [LEN_W-1:0] ent_end;
  logic [LEN_W-1:0] blk_end;

  assign live    = MY_POS < cnt_i;
  assign ent_end = {1'b0, ent_q.addr} + ent_q.size;
  assign blk_end = {1'b0, q_i.addr} + q_i.len;

  always_comb begin
    q_d  = q_i;
    p_d  = pidx_i;
    l_d  = lidx_i;
    r_d  = ridx_i;
    ex   = {1'b0, ent_q.size} == q_i.rnd;
    gt   = {1'b0, ent_q.size} > q_i.rnd;
    take = 1'b0;
    if (q_i.vld && live) begin
      // best fit: lowest-address exact hole, else smallest larger, lowest address
      if (ex) begin
        take = !q_i.exact || (ent_q.addr < q_i.paddr);
      end else if (gt && !q_i.exact) begin
        take = !q_i.found || (ent_q.size < q_i.psize) ||
               ((ent_q.size == q_i.psize) && (ent_q.addr < q_i.paddr));
      end
      if (take) begin
        q_d.found = 1'b1;
        q_d.exact = ex;
        q_d.paddr = ent_q.addr;
        q_d.psize = ent_q.size;
        p_d       = MY_IDX;
      end
      // neighbours of a block being returned
      if (ent_end == {1'b0, q_i.addr}) begin
        q_d.lfound = 1'b1;
        q_d.laddr  = ent_q.addr;
        q_d.lsize  = ent_q.size;
        l_d        = MY_IDX;
      end
      if ({1'b0, ent_q.addr} == blk_end) begin
        q_d.rfound = 1'b1;
        q_d.rsize  = ent_q.size;
        r_d        = MY_IDX;
      end
    end
  end

  always_comb begin
    ent_d = ent_q;
    case (upd_i.cmd)
      UPD_WRITE: if (uidx_i == MY_IDX) ent_d = upd_i.ent;
      UPD_SHIFT: if (uidx_i <= MY_IDX) ent_d = nxt_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_q <= INIT;
      q_q   <= '0;
    end else begin
      ent_q <= ent_d;
      q_q   <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    l_q <= l_d;
    r_q <= r_d;
  end

  assign q_o    = q_q;
  assign pidx_o = p_q;
  assign lidx_o = l_q;
  assign ridx_o = r_q;
  assign ent_o  = ent_q;

endmodule

[rtl/core/bfa_blk_cell.sv]
// One cell of the granted-block chain: holds a record, matches the passing query.
// Depends on bfa_pkg.
`timescale 1ns / 1ps

module bfa_blk_cell #(
  parameter int IDX = 0,
  parameter int IW  = 6,
  parameter int CW  = 7
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [CW-1:0]      cnt_i,
  input  bfa_pkg::blk_qry_t  q_i,
  input  logic [IW-1:0]      idx_i,
  output bfa_pkg::blk_qry_t  q_o,
  output logic [IW-1:0]      idx_o,
  input  bfa_pkg::blk_upd_t  upd_i,
  input  logic [IW-1:0]      uidx_i,
  input  bfa_pkg::blk_t      nxt_i,
  output bfa_pkg::blk_t      ent_o
);
  import bfa_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);
  localparam logic [CW-1:0] MY_POS = CW'(IDX);

  blk_t             ent_q, ent_d;
  blk_qry_t         q_q, q_d;
  logic [IW-1:0]    i_q, i_d;
  logic             live, hit;
  logic [RND_W-1:0] req_end;

  assign live    = MY_POS < cnt_i;
  assign req_end = RND_W'(ent_q.addr) + RND_W'(ent_q.req);

  always_comb begin
    q_d = q_i;
    i_d = idx_i;
    if (q_i.chk) begin
      hit = (ent_q.owner == q_i.owner) && (ent_q.addr <= q_i.addr) &&
            (RND_W'(q_i.addr) < req_end);
    end else begin
      hit = ent_q.addr == q_i.addr;
    end
    if (q_i.vld && live && !q_i.found && hit) begin
      q_d.found = 1'b1;
      q_d.faddr = ent_q.addr;
      q_d.freq  = ent_q.req;
      q_d.fact  = ent_q.act;
      i_d       = MY_IDX;
    end
  end

  always_comb begin
    ent_d = ent_q;
    case (upd_i.cmd)
      UPD_WRITE: if (uidx_i == MY_IDX) ent_d = upd_i.ent;
      UPD_SHIFT: if (uidx_i <= MY_IDX) ent_d = nxt_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_q <= '0;
    end else begin
      q_q <= q_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
    i_q   <= i_d;
  end

  assign q_o   = q_q;
  assign idx_o = i_q;
  assign ent_o = ent_q;

endmodule

[rtl/core/best_fit_block_allocator_top.sv]
// Best-fit block allocator top level: a chain of hole cells, a chain of block cells, a sequencer.
// Steps, request to result: allocate runs rounding, hole scan, update and output; free runs
// block scan, hole scan, update and output (one more update step when it merges on both
// sides); check runs block scan and output; rejected requests go straight to output. One item in
// flight; the next is taken in the cycle after the result is registered; output stalls hold it off.
// Reset: one hole covering the whole pool, no blocks, granule 8; no clearing pass.
`timescale 1ns / 1ps

module best_fit_block_allocator_top #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // config: granule_bytes
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,
  // request items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,  // mode[1:0]
  input  logic [47:0] s_axis_tdata,  // owner_id[15:0], address[28:16], size[42:29]
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // block_address[12:0], length[26:13], status[29:27]
);
  import bfa_pkg::*;

  // hole chain: holes never touch, so there are at most one more than blocks
  localparam int HN  = TABLE_ENTRIES + 1;
  localparam int HIW = $clog2(HN);
  localparam int HCW = $clog2(HN + 1);
  localparam int BN  = TABLE_ENTRIES;
  localparam int BIW = $clog2(BN);
  localparam int BCW = $clog2(BN + 1);

  fsm_e state_q, state_d;

  // request fields
  logic [MODE_W-1:0] in_mode;
  logic [OWN_W-1:0]  in_own;
  logic [ADDR_W-1:0] in_addr;
  logic [LEN_W-1:0]  in_size;
  logic              in_acc;

  logic [MODE_W-1:0] mode_q, mode_d;
  logic [OWN_W-1:0]  own_q, own_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [LEN_W-1:0]  size_q, size_d;

  logic [GRAN_W-1:0] gran_q, gran_d;
  logic [GRAN_W-1:0] cfg_g;

  logic [HCW-1:0] hcnt_q, hcnt_d;
  logic [BCW-1:0] bcnt_q, bcnt_d;

  // scan results kept for the update step
  hole_qry_t      hres_q, hres_d;
  logic [HIW-1:0] hpi_q, hpi_d, hli_q, hli_d, hri_q, hri_d;
  logic [LEN_W-1:0] blen_q, blen_d;

  // pending result and output register
  logic [ADDR_W-1:0] res_addr_q, res_addr_d;
  logic [LEN_W-1:0]  res_len_q, res_len_d;
  status_e           res_st_q, res_st_d;
  logic              out_vld_q, out_vld_d;
  logic [ADDR_W-1:0] out_addr_q, out_addr_d;
  logic [LEN_W-1:0]  out_len_q, out_len_d;
  status_e           out_st_q, out_st_d;

  // rounding unit
  logic             div_start, div_done;
  logic             div_go_q;
  logic [RND_W-1:0] div_rnd;

  // chain wiring
  hole_qry_t      hq_in;
  hole_qry_t      hq  [HN+1];
  logic [HIW-1:0] hp  [HN+1];
  logic [HIW-1:0] hl  [HN+1];
  logic [HIW-1:0] hr  [HN+1];
  hole_t          hent[HN];
  hole_upd_t      hupd;
  logic [HIW-1:0] huidx;

  blk_qry_t       bq_in;
  blk_qry_t       bq  [BN+1];
  logic [BIW-1:0] bi  [BN+1];
  blk_t           bent[BN];
  blk_upd_t       bupd;
  logic [BIW-1:0] buidx;

  // update-step arithmetic
  logic [RND_W-1:0] spare;
  logic             whole;
  logic [LEN_W-1:0] granted;
  logic [RND_W-1:0] avail;

  assign in_mode = s_axis_tuser;
  assign in_own  = s_axis_tdata[15:0];
  assign in_addr = s_axis_tdata[28:16];
  assign in_size = s_axis_tdata[42:29];

  assign s_axis_tready = state_q == S_IDLE;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // granule: anything up to 8 acts as 8, else round up to a multiple of 8
  assign cfg_g  = {1'b0, cfg_wr_data_i} + GRAN_W'(7);
  assign gran_d = cfg_wr_en_i ?
                  ((cfg_wr_data_i <= CFG_W'(MIN_GRAN)) ? GRAN_W'(MIN_GRAN) :
                   {cfg_g[GRAN_W-1:3], 3'b000}) : gran_q;

  bfa_gran_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go_q),
    .size_i  (size_q),
    .gran_i  (gran_q),
    .done_o  (div_done),
    .rnd_o   (div_rnd)
  );

  // hole chain
  assign hq[0] = hq_in;
  assign hp[0] = '0;
  assign hl[0] = '0;
  assign hr[0] = '0;

  for (genvar k = 0; k < HN; k++) begin : g_hole
    hole_t nxt;
    if (k == HN - 1) begin : g_end
      assign nxt = hent[k];
    end else begin : g_mid
      assign nxt = hent[k+1];
    end
    bfa_hole_cell #(
      .IDX      (k),
      .IW       (HIW),
      .CW       (HCW),
      .IS_FIRST (k == 0)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cnt_i  (hcnt_q),
      .q_i    (hq[k]),
      .pidx_i (hp[k]),
      .lidx_i (hl[k]),
      .ridx_i (hr[k]),
      .q_o    (hq[k+1]),
      .pidx_o (hp[k+1]),
      .lidx_o (hl[k+1]),
      .ridx_o (hr[k+1]),
      .upd_i  (hupd),
      .uidx_i (huidx),
      .nxt_i  (nxt),
      .ent_o  (hent[k])
    );
  end

  // block chain
  assign bq[0] = bq_in;
  assign bi[0] = '0;

  for (genvar k = 0; k < BN; k++) begin : g_blk
    blk_t nxt;
    if (k == BN - 1) begin : g_end
      assign nxt = bent[k];
    end else begin : g_mid
      assign nxt = bent[k+1];
    end
    bfa_blk_cell #(
      .IDX (k),
      .IW  (BIW),
      .CW  (BCW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cnt_i  (bcnt_q),
      .q_i    (bq[k]),
      .idx_i  (bi[k]),
      .q_o    (bq[k+1]),
      .idx_o  (bi[k+1]),
      .upd_i  (bupd),
      .uidx_i (buidx),
      .nxt_i  (nxt),
      .ent_o  (bent[k])
    );
  end

  assign spare   = {1'b0, hres_q.psize} - div_rnd;
  assign whole   = hres_q.exact || (spare < RND_W'(gran_q));
  assign granted = whole ? hres_q.psize : div_rnd[LEN_W-1:0];
  assign avail   = RND_W'(bq[BN].faddr) + RND_W'(bq[BN].freq) - RND_W'(addr_q);

  // sequencer
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    own_d      = own_q;
    addr_d     = addr_q;
    size_d     = size_q;
    hcnt_d     = hcnt_q;
    bcnt_d     = bcnt_q;
    hres_d     = hres_q;
    hpi_d      = hpi_q;
    hli_d      = hli_q;
    hri_d      = hri_q;
    blen_d     = blen_q;
    res_addr_d = res_addr_q;
    res_len_d  = res_len_q;
    res_st_d   = res_st_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_addr_d = out_addr_q;
    out_len_d  = out_len_q;
    out_st_d   = out_st_q;
    div_start  = 1'b0;
    hq_in      = '0;
    bq_in      = '0;
    hupd       = '{cmd: UPD_NONE, ent: '0};
    huidx      = '0;
    bupd       = '{cmd: UPD_NONE, ent: '0};
    buidx      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          mode_d     = in_mode;
          own_d      = in_own;
          addr_d     = in_addr;
          size_d     = in_size;
          res_addr_d = '0;
          res_len_d  = '0;
          case (in_mode)
            MODE_ALLOC: begin
              if (in_size == '0) begin
                res_st_d = ST_BADSIZE;
                state_d  = S_OUT;
              end else if (bcnt_q >= BCW'(TABLE_ENTRIES)) begin
                res_st_d = ST_FULL;
                state_d  = S_OUT;
              end else begin
                state_d = S_DIV;
              end
            end
            MODE_FREE, MODE_CHECK: state_d = S_BGO;
            default: begin
              res_st_d = ST_BADSIZE;
              state_d  = S_OUT;
            end
          endcase
        end
      end

      S_DIV: begin
        // unit starts on the first cycle here, once size_q holds the request
        if (div_done) begin
          state_d = S_HGO;
        end
      end

      S_HGO: begin
        hq_in.vld  = 1'b1;
        hq_in.rnd  = div_rnd;
        hq_in.addr = addr_q;
        hq_in.len  = blen_q;
        state_d    = S_HSCAN;
      end

      S_HSCAN: begin
        if (hq[HN].vld) begin
          hres_d  = hq[HN];
          hpi_d   = hp[HN];
          hli_d   = hl[HN];
          hri_d   = hr[HN];
          state_d = S_HUPD;
        end
      end

      S_HUPD: begin
        state_d = S_OUT;
        if (mode_q == MODE_ALLOC) begin
          if (!hres_q.found) begin
            res_st_d = ST_NOMEM;
          end else begin
            huidx = hpi_q;
            if (whole) begin
              hupd.cmd = UPD_SHIFT;
              hcnt_d   = hcnt_q - 1'b1;
            end else begin
              hupd.cmd      = UPD_WRITE;
              hupd.ent.addr = hres_q.paddr + div_rnd[ADDR_W-1:0];
              hupd.ent.size = spare[LEN_W-1:0];
            end
            bupd.cmd       = UPD_WRITE;
            bupd.ent.owner = own_q;
            bupd.ent.req   = size_q;
            bupd.ent.act   = granted;
            bupd.ent.addr  = hres_q.paddr;
            buidx          = bcnt_q[BIW-1:0];
            bcnt_d         = bcnt_q + 1'b1;
            res_addr_d     = hres_q.paddr;
            res_len_d      = granted;
            res_st_d       = ST_OK;
          end
        end else begin
          // returned block: merge with neighbours
          hupd.cmd = UPD_WRITE;
          if (hres_q.lfound && hres_q.rfound) begin
            huidx         = hli_q;
            hupd.ent.addr = hres_q.laddr;
            hupd.ent.size = hres_q.lsize + blen_q + hres_q.rsize;
            state_d       = S_HUPD2;
          end else if (hres_q.lfound) begin
            huidx         = hli_q;
            hupd.ent.addr = hres_q.laddr;
            hupd.ent.size = hres_q.lsize + blen_q;
          end else if (hres_q.rfound) begin
            huidx         = hri_q;
            hupd.ent.addr = addr_q;
            hupd.ent.size = blen_q + hres_q.rsize;
          end else begin
            huidx         = hcnt_q[HIW-1:0];
            hupd.ent.addr = addr_q;
            hupd.ent.size = blen_q;
            hcnt_d        = hcnt_q + 1'b1;
          end
        end
      end

      S_HUPD2: begin
        // right neighbour now lives inside the left one
        hupd.cmd = UPD_SHIFT;
        huidx    = hri_q;
        hcnt_d   = hcnt_q - 1'b1;
        state_d  = S_OUT;
      end

      S_BGO: begin
        bq_in.vld   = 1'b1;
        bq_in.chk   = mode_q == MODE_CHECK;
        bq_in.owner = own_q;
        bq_in.addr  = addr_q;
        state_d     = S_BSCAN;
      end

      S_BSCAN: begin
        if (bq[BN].vld) begin
          state_d = S_OUT;
          if (!bq[BN].found) begin
            res_st_d = ST_UNKNOWN;
          end else if (mode_q == MODE_CHECK) begin
            res_len_d = avail[LEN_W-1:0];
            res_st_d  = (avail < RND_W'(size_q)) ? ST_SHORT : ST_OK;
          end else begin
            blen_d    = bq[BN].fact;
            res_len_d = bq[BN].fact;
            res_st_d  = ST_OK;
            bupd.cmd  = UPD_SHIFT;
            buidx     = bi[BN];
            bcnt_d    = bcnt_q - 1'b1;
            state_d   = S_HGO;
          end
        end
      end

      S_OUT: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_addr_d = res_addr_q;
          out_len_d  = res_len_q;
          out_st_d   = res_st_q;
          state_d    = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (state_q == S_IDLE && state_d == S_DIV) begin
      div_start = 1'b1;
    end
  end

  // size_q is loaded on the accepting edge, so the start pulse is registered through div_go_q
  // and the unit samples the new size
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_go_q <= 1'b0;
    end else begin
      div_go_q <= div_start;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      gran_q    <= GRAN_W'(MIN_GRAN);
      hcnt_q    <= HCW'(1);
      bcnt_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      gran_q    <= gran_d;
      hcnt_q    <= hcnt_d;
      bcnt_q    <= bcnt_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    own_q      <= own_d;
    addr_q     <= addr_d;
    size_q     <= size_d;
    hres_q     <= hres_d;
    hpi_q      <= hpi_d;
    hli_q      <= hli_d;
    hri_q      <= hri_d;
    blen_q     <= blen_d;
    res_addr_q <= res_addr_d;
    res_len_q  <= res_len_d;
    res_st_q   <= res_st_d;
    out_addr_q <= out_addr_d;
    out_len_q  <= out_len_d;
    out_st_q   <= out_st_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {2'b00, out_st_q, out_len_q, out_addr_q};

  // assertions
  a_hcnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hcnt_q <= HCW'(HN))
    else $error("hole count beyond chain length");

  a_bcnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (bcnt_q != $past(bcnt_q)) |->
      ((bcnt_q == $past(bcnt_q) + 1'b1) || (bcnt_q == $past(bcnt_q) - 1'b1)))
    else $error("block count moved by more than one");

  a_hole_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hq[HN].vld |-> (state_q == S_HSCAN))
    else $error("hole scan result arrived outside the scan wait");

  a_blk_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bq[BN].vld |-> (state_q == S_BSCAN))
    else $error("block scan result arrived outside the scan wait");

  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV) && !div_go_q)
    else $error("rounding finished outside its wait");

endmodule

[bench/best_fit_block_allocator_checker.sv]
// Checker for the best-fit block allocator: watches the request, result and config ports,
// keeps its own copy of the hole list and block table, and compares each result item.
// Depends on bfa_pkg for field widths and status codes.
`timescale 1ns / 1ps

module best_fit_block_allocator_checker #(
  parameter int TABLE_ENTRIES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_wr_en_i,
  input  logic [10:0] cfg_wr_data_i,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [1:0]  s_axis_tuser,
  input  logic [47:0] s_axis_tdata,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  output int          fail_count_o,
  output int          pending_o
);
  import bfa_pkg::*;

  localparam int HOLE_SLOTS = TABLE_ENTRIES + 1;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    status_e           status;
  } grant_t;

  // shadow pool state
  int unsigned hole_addr [HOLE_SLOTS];
  int unsigned hole_size [HOLE_SLOTS];
  int unsigned hole_num;
  int unsigned blk_owner [TABLE_ENTRIES];
  int unsigned blk_req   [TABLE_ENTRIES];
  int unsigned blk_act   [TABLE_ENTRIES];
  int unsigned blk_addr  [TABLE_ENTRIES];
  int unsigned blk_num;
  int unsigned granule;

  grant_t grants_due[$];

  function automatic void drop_hole(int unsigned p);
    for (int unsigned k = p; k + 1 < hole_num; k++) begin
      hole_addr[k] = hole_addr[k+1];
      hole_size[k] = hole_size[k+1];
    end
    hole_num--;
  endfunction

  function automatic grant_t serve(logic [1:0] mode, int unsigned owner, int unsigned addr,
                                   int unsigned size);
    grant_t g;
    int unsigned i, rnd, pick, bsz, avail;
    bit found, exact, left, right;
    g = '{addr: '0, len: '0, status: ST_OK};
    if (mode == MODE_ALLOC) begin
      if (size == 0) g.status = ST_BADSIZE;
      else if (blk_num >= TABLE_ENTRIES) g.status = ST_FULL;
      else begin
        rnd = size;
        if (size % granule != 0) rnd = size + granule - size % granule;
        found = 0; exact = 0; pick = 0;
        for (i = 0; i < hole_num; i++) begin
          if (hole_size[i] == rnd) begin
            pick = i; found = 1; exact = 1; break;
          end
          if (hole_size[i] > rnd && (!found || hole_size[i] < hole_size[pick])) begin
            pick = i; found = 1;
          end
        end
        if (!found) g.status = ST_NOMEM;
        else begin
          g.addr = ADDR_W'(hole_addr[pick]);
          if (!exact && hole_size[pick] - rnd >= granule) begin
            bsz = rnd;
            hole_addr[pick] += rnd;
            hole_size[pick] -= rnd;
          end else begin
            bsz = hole_size[pick];
            drop_hole(pick);
          end
          blk_owner[blk_num] = owner;
          blk_req[blk_num]   = size;
          blk_act[blk_num]   = bsz;
          blk_addr[blk_num]  = hole_addr_of(g.addr);
          blk_num++;
          g.len = LEN_W'(bsz);
        end
      end
    end else if (mode == MODE_FREE) begin
      for (i = 0; i < blk_num; i++) if (blk_addr[i] == addr) break;
      if (i >= blk_num) g.status = ST_UNKNOWN;
      else begin
        bsz = blk_act[i];
        for (int unsigned k = i; k + 1 < blk_num; k++) begin
          blk_owner[k] = blk_owner[k+1];
          blk_req[k]   = blk_req[k+1];
          blk_act[k]   = blk_act[k+1];
          blk_addr[k]  = blk_addr[k+1];
        end
        blk_num--;
        // return the block to the hole list, merging with neighbours
        pick = 0;
        while (pick < hole_num && hole_addr[pick] < addr) pick++;
        left  = pick > 0 && hole_addr[pick-1] + hole_size[pick-1] == addr;
        right = pick < hole_num && addr + bsz == hole_addr[pick];
        if (left && right) begin
          hole_size[pick-1] += bsz + hole_size[pick];
          drop_hole(pick);
        end else if (left) hole_size[pick-1] += bsz;
        else if (right) begin
          hole_addr[pick] = addr;
          hole_size[pick] += bsz;
        end else if (hole_num < HOLE_SLOTS) begin
          for (int unsigned k = hole_num; k > pick; k--) begin
            hole_addr[k] = hole_addr[k-1];
            hole_size[k] = hole_size[k-1];
          end
          hole_addr[pick] = addr;
          hole_size[pick] = bsz;
          hole_num++;
        end
        g.len = LEN_W'(bsz);
      end
    end else if (mode == MODE_CHECK) begin
      for (i = 0; i < blk_num; i++)
        if (blk_owner[i] == owner && blk_addr[i] <= addr && addr < blk_addr[i] + blk_req[i])
          break;
      if (i >= blk_num) g.status = ST_UNKNOWN;
      else begin
        avail  = blk_addr[i] + blk_req[i] - addr;
        g.len  = LEN_W'(avail);
        g.status = (avail < size) ? ST_SHORT : ST_OK;
      end
    end else begin
      g.status = ST_BADSIZE;
    end
    return g;
  endfunction

  // granted address back to a plain number for the table
  function automatic int unsigned hole_addr_of(logic [ADDR_W-1:0] a);
    return int'(a);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    grant_t want, got;
    int unsigned gv;
    if (!rst_ni) begin
      hole_addr[0] = 0;
      hole_size[0] = POOL_BYTES;
      hole_num     = 1;
      blk_num      = 0;
      granule      = MIN_GRAN;
      grants_due.delete();
      fail_count_o = 0;
    end else begin
      if (cfg_wr_en_i) begin
        gv = int'(cfg_wr_data_i);
        granule = (gv <= MIN_GRAN) ? MIN_GRAN : ((gv + 7) & ~32'd7);
      end
      if (s_axis_tvalid && s_axis_tready)
        grants_due.push_back(serve(s_axis_tuser, int'(s_axis_tdata[15:0]),
                                   int'(s_axis_tdata[28:16]), int'(s_axis_tdata[42:29])));
      if (m_axis_tvalid && m_axis_tready) begin
        got = '{addr: m_axis_tdata[12:0], len: m_axis_tdata[26:13],
                status: status_e'(m_axis_tdata[29:27])};
        if (grants_due.size() == 0) begin
          $display("%0t: result with none expected: addr %0d len %0d status %0d",
                   $time, got.addr, got.len, got.status);
          fail_count_o++;
        end else begin
          want = grants_due.pop_front();
          if (got.addr != want.addr) begin
            $display("%0t: block_address expected %0d actual %0d", $time, want.addr, got.addr);
            fail_count_o++;
          end
          if (got.len != want.len) begin
            $display("%0t: length expected %0d actual %0d", $time, want.len, got.len);
            fail_count_o++;
          end
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count_o++;
          end
        end
      end
    end
    pending_o = grants_due.size();
  end

endmodule

[bench/best_fit_block_allocator_top_test.sv]
// Testbench top for the best-fit block allocator: clock, reset, request and config stimulus,
// result back-pressure, watchdog and verdict. Depends on bfa_pkg, the block and the checker.
`timescale 1ns / 1ps

module best_fit_block_allocator_top_test;
  import bfa_pkg::*;

  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;  // unused opcode
  localparam int IDLE_LIMIT = 5000;                 // cycles with no item moving
  localparam int HOLD_CYCLES = 400;                 // long receiver hold-off

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_wr_en_i = 1'b0;
  logic [10:0] cfg_wr_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [1:0]  s_axis_tuser = '0;
  logic [47:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  int          fail_count, pending;

  // what was sent, so result items can be tied back to their request
  typedef struct {
    logic [1:0]  mode;
    logic [15:0] owner;
  } sent_t;
  // blocks believed live, used to aim frees and checks at real addresses
  typedef struct {
    int unsigned addr;
    int unsigned owner;
    int unsigned len;
  } live_t;

  sent_t sent_q[$];
  live_t live_q[$];
  bit    idle_on = 1'b1;  // cleared for stretches with no gaps
  int    results_seen = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  best_fit_block_allocator_top u_dut (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  best_fit_block_allocator_checker u_chk (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result side: random stalls, plus one long hold-off once traffic is flowing
  always @(posedge clk_i or negedge rst_ni) begin
    int stall_left;
    bit held;
    bit rdy;
    if (!rst_ni) begin
      stall_left = 0;
      held = 0;
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) results_seen++;
      if (!held && results_seen == 60) begin
        held = 1;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (idle_on && $urandom_range(0, 99) < 20)
          stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50)
                                                   : $urandom_range(1, 3);
      end
      m_axis_tready <= rdy;
    end
  end

  // learn granted blocks from result items
  always @(posedge clk_i) begin
    sent_t s;
    if (rst_ni && m_axis_tvalid && m_axis_tready && sent_q.size() != 0) begin
      s = sent_q.pop_front();
      if (s.mode == MODE_ALLOC && m_axis_tdata[29:27] == ST_OK)
        live_q.push_back('{addr: m_axis_tdata[12:0], owner: s.owner,
                           len: m_axis_tdata[26:13]});
    end
  end

  // watchdog: nothing accepted on either side for too long
  always @(posedge clk_i) begin
    int quiet;
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      quiet = 0;
    else if (++quiet >= IDLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_req(input logic [1:0] mode, input logic [15:0] owner,
                          input logic [12:0] addr, input logic [13:0] size);
    int g;
    g = gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= mode;
    s_axis_tdata  <= {5'b00000, size, addr, owner};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_q.push_back('{mode: mode, owner: owner});
  endtask

  // quiesce, then write the granule register
  task automatic set_granule(input logic [10:0] val);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    cfg_wr_en_i   <= 1'b1;
    cfg_wr_data_i <= val;
    @(posedge clk_i);
    cfg_wr_en_i <= 1'b0;
  endtask

  // one random request; alloc_pct biases towards allocation to fill the table
  task automatic random_req(input int alloc_pct);
    int r, k;
    live_t e;
    logic [15:0] own;
    logic [13:0] sz;
    r = $urandom_range(0, 99);
    own = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 7));
    if (r < alloc_pct) begin
      case ($urandom_range(0, 19))
        0:       sz = 14'($urandom);
        1:       sz = 14'($urandom_range(0, 8192));
        2:       sz = 0;
        3, 4:    sz = 14'($urandom_range(257, 2048));
        default: sz = 14'($urandom_range(1, 256));
      endcase
      send_req(MODE_ALLOC, own, 13'($urandom), sz);
    end else if (r < alloc_pct + (100 - alloc_pct) * 6 / 10) begin
      if (live_q.size() != 0 && $urandom_range(0, 9) < 8) begin
        k = $urandom_range(0, live_q.size() - 1);
        e = live_q[k];
        live_q.delete(k);
        send_req(MODE_FREE, own, 13'(e.addr), 14'($urandom));
      end else
        send_req(MODE_FREE, own, 13'($urandom), 14'($urandom));
    end else if (r < 97) begin
      if (live_q.size() != 0 && $urandom_range(0, 9) < 8) begin
        e = live_q[$urandom_range(0, live_q.size() - 1)];
        if ($urandom_range(0, 3) == 0) e.owner = own;
        send_req(MODE_CHECK, 16'(e.owner), 13'(e.addr + $urandom_range(0, e.len - 1)),
                 14'($urandom_range(0, e.len + 16)));
      end else
        send_req(MODE_CHECK, own, 13'($urandom), 14'($urandom));
    end else
      send_req(MODE_SPARE, 16'($urandom), 13'($urandom), 14'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: rejects, whole pool, rounding, splits and merges
    idle_on = 1'b0;
    send_req(MODE_ALLOC, 16'd1, 13'd0, 14'd0);           // zero size
    send_req(MODE_SPARE, 16'hFFFF, 13'h1FFF, 14'h3FFF);  // unused opcode
    send_req(MODE_FREE, 16'd1, 13'd0, 14'd0);            // nothing to free
    send_req(MODE_CHECK, 16'd1, 13'd0, 14'd0);           // no block at all
    send_req(MODE_ALLOC, 16'hFFFF, 13'h1FFF, 14'd8192);  // whole pool
    send_req(MODE_ALLOC, 16'd1, 13'd0, 14'd1);           // out of memory
    send_req(MODE_CHECK, 16'hFFFF, 13'h1FFF, 14'd1);     // last byte
    send_req(MODE_CHECK, 16'hFFFF, 13'd100, 14'h3FFF);   // range too long
    send_req(MODE_CHECK, 16'hFFFF, 13'd0, 14'd0);        // zero length inside
    send_req(MODE_CHECK, 16'd2, 13'd0, 14'd1);           // wrong owner
    send_req(MODE_FREE, 16'd9, 13'd0, 14'd0);            // free ignores owner
    send_req(MODE_ALLOC, 16'd1, 13'd0, 14'h3FFF);        // larger than pool
    idle_on = 1'b1;
    send_req(MODE_ALLOC, 16'd1, 13'd0, 14'd5);           // rounds to 8 at 0
    send_req(MODE_ALLOC, 16'd2, 13'd0, 14'd24);          // at 8
    send_req(MODE_ALLOC, 16'd3, 13'd0, 14'd8);           // at 32
    send_req(MODE_FREE, 16'd2, 13'd8, 14'd0);            // hole between blocks
    send_req(MODE_ALLOC, 16'd4, 13'd0, 14'd17);          // exact hole at 8
    send_req(MODE_FREE, 16'd0, 13'd0, 14'd0);
    send_req(MODE_FREE, 16'd0, 13'd32, 14'd0);           // merges with tail hole
    send_req(MODE_FREE, 16'd0, 13'd8, 14'd0);            // merges on both sides
    send_req(MODE_CHECK, 16'd1, 13'd4, 14'd1);           // freed block gone

    // random phases over several granules, extremes included
    set_granule(11'd0);
    for (int n = 0; n < 90; n++) random_req(80);  // fills the table
    set_granule(11'd2047);
    idle_on = 1'b0;
    for (int n = 0; n < 50; n++) random_req(40);
    idle_on = 1'b1;
    set_granule(11'd1024);
    for (int n = 0; n < 60; n++) random_req(40);
    set_granule(11'd100);
    for (int n = 0; n < 70; n++) random_req(45);
    set_granule(11'd9);
    for (int n = 0; n < 60; n++) random_req(45);
    set_granule(11'd8);
    for (int n = 0; n < 70; n++) random_req(45);
    s_axis_tvalid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
